// ===== rtl/gsrd_pkg.sv =====
// ----------------------------------------------------------------------------
// gsrd_pkg
// types and constants shared by the gamepad serial report decoder
// ----------------------------------------------------------------------------
`default_nettype none

package gsrd_pkg;

    localparam int CAPTURE_DEPTH = 24;
    localparam int CAP_IDX_W     = $clog2(CAPTURE_DEPTH);
    localparam int CAP_POS_W     = $clog2(CAPTURE_DEPTH + 1);

    localparam int BUTTON_W = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 24;

    localparam logic [CFG_IDX_W-1:0] CFG_LEFT_MASK  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MASK = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT_MAC  = 2'd2;

    localparam logic [BUTTON_W-1:0] LEFT_MASK_RESET  = 24'hFFE900;
    localparam logic [BUTTON_W-1:0] RIGHT_MASK_RESET = 24'h0076FF;
    localparam logic [7:0]          RIGHT_MAC_RESET  = 8'h7C;

    localparam logic [7:0] CMD_INPUT     = 8'h92;
    localparam logic [7:0] CMD_INIT      = 8'h94;
    localparam logic [7:0] CMD_HANDSHAKE = 8'hA5;

    localparam logic [7:0] SUB_INPUT_REPORT = 8'h30;
    localparam logic [7:0] SUB_MAC          = 8'h01;
    localparam logic [7:0] SUB_BAUD         = 8'h20;
    localparam logic [7:0] SUB_INIT_A       = 8'h10;
    localparam logic [7:0] SUB_INIT_B       = 8'h11;
    localparam logic [7:0] SUB_INIT_C       = 8'h12;

    localparam int POS_CMD     = 5;
    localparam int POS_INITSUB = 6;
    localparam int POS_SUB     = 12;
    localparam int POS_BTN     = 15;
    localparam int POS_STICK   = 18;
    localparam int POS_MAC     = 18;

    localparam logic [1:0] SIDE_UNKNOWN = 2'd0;
    localparam logic [1:0] SIDE_LEFT    = 2'd1;
    localparam logic [1:0] SIDE_RIGHT   = 2'd2;

    localparam logic [8:0] STICK_Y_BASE = 9'd256;

    typedef enum logic [2:0] {
        KIND_UNKNOWN     = 3'd0,
        KIND_INPUT       = 3'd1,
        KIND_MAC         = 3'd2,
        KIND_BAUD        = 3'd3,
        KIND_INIT_OTHER  = 3'd4,
        KIND_HANDSHAKE   = 3'd5,
        KIND_UNKNOWN_SUB = 3'd6
    } packet_kind_t;

endpackage

`default_nettype wire

// ===== rtl/gsrd_in_if.sv =====
// ----------------------------------------------------------------------------
// gsrd_in_if
// request channel carrying one received serial byte
// ----------------------------------------------------------------------------
`default_nettype none

interface gsrd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_buffer;

    modport source (output valid, output rx_byte, output end_of_buffer, input ready);
    modport sink   (input valid, input rx_byte, input end_of_buffer, output ready);
endinterface

`default_nettype wire

// ===== rtl/gsrd_out_if.sv =====
// ----------------------------------------------------------------------------
// gsrd_out_if
// result channel carrying one decoded report
// ----------------------------------------------------------------------------
`default_nettype none

interface gsrd_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  packet_kind;
    logic [23:0] merged_buttons;
    logic [7:0]  left_stick_x;
    logic [8:0]  left_stick_y;
    logic [7:0]  right_stick_x;
    logic [8:0]  right_stick_y;
    logic [1:0]  side_select;
    logic        handshake_seen;
    logic        baud_switch_request;
    logic [15:0] report_count;

    modport source (
        output valid, input ready,
        output packet_kind, output merged_buttons,
        output left_stick_x, output left_stick_y,
        output right_stick_x, output right_stick_y,
        output side_select, output handshake_seen,
        output baud_switch_request, output report_count
    );
    modport sink (
        input valid, output ready,
        input packet_kind, input merged_buttons,
        input left_stick_x, input left_stick_y,
        input right_stick_x, input right_stick_y,
        input side_select, input handshake_seen,
        input baud_switch_request, input report_count
    );
endinterface

`default_nettype wire

// ===== rtl/gamepad_serial_report_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// gamepad_serial_report_decoder_unit
// Takes one serial byte per request and decodes the buffer at its end mark.
// One byte is accepted every cycle while the input side is not held. A byte
// waits in the input register, then the capture, decode and merge logic
// updates the held state; on the byte marked end of buffer the result
// register loads the decoded report. The input register keeps taking bytes
// while a finished report waits; only an end-marked byte that meets a full
// result register holds the input side.
// ----------------------------------------------------------------------------
`default_nettype none

module gamepad_serial_report_decoder_unit
    import gsrd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    gsrd_in_if.sink                    in_ch,
    gsrd_out_if.source                 out_ch
);

    logic [BUTTON_W-1:0] left_mask_reg;
    logic [BUTTON_W-1:0] right_mask_reg;
    logic [7:0]          right_mac_reg;

    logic       s1_valid_reg;
    logic [7:0] s1_byte_reg;
    logic       s1_eob_reg;
    logic       go;

    logic [CAP_POS_W-1:0] pos_reg, pos_next;
    logic [7:0] cap_reg [CAPTURE_DEPTH];
    logic [7:0] cap_next [CAPTURE_DEPTH];
    logic [7:0] eff [CAPTURE_DEPTH];

    logic [BUTTON_W-1:0] buttons_reg, buttons_next;
    logic [7:0]  lx_reg, lx_next;
    logic [8:0]  ly_reg, ly_next;
    logic [7:0]  rx_reg, rx_next;
    logic [8:0]  ry_reg, ry_next;
    logic [1:0]  side_reg, side_next;
    logic        hs_reg, hs_next;
    logic [15:0] count_reg, count_next;

    logic [BUTTON_W-1:0] fresh;
    packet_kind_t        kind;
    logic                in_range;

    logic                out_valid_reg;
    packet_kind_t        out_kind_reg;
    logic [BUTTON_W-1:0] out_buttons_reg;
    logic [7:0]          out_lx_reg;
    logic [8:0]          out_ly_reg;
    logic [7:0]          out_rx_reg;
    logic [8:0]          out_ry_reg;
    logic [1:0]          out_side_reg;
    logic                out_hs_reg;
    logic                out_baud_reg;
    logic [15:0]         out_count_reg;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_mask_reg  <= LEFT_MASK_RESET;
            right_mask_reg <= RIGHT_MASK_RESET;
            right_mac_reg  <= RIGHT_MAC_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_LEFT_MASK:  left_mask_reg  <= cfg_data[BUTTON_W-1:0];
                CFG_RIGHT_MASK: right_mask_reg <= cfg_data[BUTTON_W-1:0];
                CFG_RIGHT_MAC:  right_mac_reg  <= cfg_data[7:0];
                default:        ;
            endcase
        end
    end

    // input register
    assign go          = s1_valid_reg && (!s1_eob_reg || !out_valid_reg || out_ch.ready);
    assign in_ch.ready = !s1_valid_reg || go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ch.ready)
        begin
            s1_valid_reg <= in_ch.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ch.ready && in_ch.valid)
        begin
            s1_byte_reg <= in_ch.rx_byte;
            s1_eob_reg  <= in_ch.end_of_buffer;
        end
    end

    // capture, decode and merge
    assign in_range = (pos_reg < CAP_POS_W'(CAPTURE_DEPTH));

    always_comb
    begin
        for (int k = 0; k < CAPTURE_DEPTH; k++)
        begin
            if (in_range && (pos_reg[CAP_IDX_W-1:0] == CAP_IDX_W'(k)))
                eff[k] = s1_byte_reg;
            else
                eff[k] = cap_reg[k];
        end

        fresh = {eff[POS_BTN+2], eff[POS_BTN+1], eff[POS_BTN]};

        buttons_next = buttons_reg;
        lx_next      = lx_reg;
        ly_next      = ly_reg;
        rx_next      = rx_reg;
        ry_next      = ry_reg;
        side_next    = side_reg;
        hs_next      = hs_reg;
        count_next   = count_reg;
        kind         = KIND_UNKNOWN;

        case (eff[POS_CMD])
            CMD_INPUT:
            begin
                if (eff[POS_SUB] == SUB_INPUT_REPORT)
                begin
                    kind = KIND_INPUT;
                    if (side_reg[0])
                    begin
                        buttons_next = (buttons_next & ~left_mask_reg) | (fresh & left_mask_reg);
                        lx_next = {eff[POS_STICK+1][3:0], eff[POS_STICK][7:4]};
                        ly_next = STICK_Y_BASE - {1'b0, eff[POS_STICK+2]};
                    end
                    if (side_reg[1])
                    begin
                        buttons_next = (buttons_next & ~right_mask_reg)
                                     | (fresh & right_mask_reg);
                        rx_next = {eff[POS_STICK+4][3:0], eff[POS_STICK+3][7:4]};
                        ry_next = STICK_Y_BASE - {1'b0, eff[POS_STICK+5]};
                    end
                    count_next = count_reg + 16'd1;
                end
                else
                begin
                    kind = KIND_UNKNOWN_SUB;
                end
            end
            CMD_INIT:
            begin
                case (eff[POS_INITSUB])
                    SUB_MAC:
                    begin
                        kind      = KIND_MAC;
                        side_next = (eff[POS_MAC] != right_mac_reg) ? SIDE_LEFT : SIDE_RIGHT;
                    end
                    SUB_BAUD:   kind = KIND_BAUD;
                    SUB_INIT_A: kind = KIND_INIT_OTHER;
                    SUB_INIT_B: kind = KIND_INIT_OTHER;
                    SUB_INIT_C: kind = KIND_INIT_OTHER;
                    default:    kind = KIND_UNKNOWN_SUB;
                endcase
            end
            CMD_HANDSHAKE:
            begin
                kind    = KIND_HANDSHAKE;
                hs_next = 1'b1;
            end
            default: kind = KIND_UNKNOWN;
        endcase

        // capture and position updates
        for (int k = 0; k < CAPTURE_DEPTH; k++)
        begin
            if (!go)
                cap_next[k] = cap_reg[k];
            else if (s1_eob_reg)
                cap_next[k] = 8'd0;
            else
                cap_next[k] = eff[k];
        end

        if (!go)
            pos_next = pos_reg;
        else if (s1_eob_reg)
            pos_next = '0;
        else if (in_range)
            pos_next = pos_reg + CAP_POS_W'(1);
        else
            pos_next = pos_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg     <= '0;
            buttons_reg <= '0;
            lx_reg      <= '0;
            ly_reg      <= '0;
            rx_reg      <= '0;
            ry_reg      <= '0;
            side_reg    <= SIDE_UNKNOWN;
            hs_reg      <= 1'b0;
            count_reg   <= '0;
            for (int k = 0; k < CAPTURE_DEPTH; k++)
                cap_reg[k] <= 8'd0;
        end
        else
        begin
            pos_reg <= pos_next;
            for (int k = 0; k < CAPTURE_DEPTH; k++)
                cap_reg[k] <= cap_next[k];
            if (go && s1_eob_reg)
            begin
                buttons_reg <= buttons_next;
                lx_reg      <= lx_next;
                ly_reg      <= ly_next;
                rx_reg      <= rx_next;
                ry_reg      <= ry_next;
                side_reg    <= side_next;
                hs_reg      <= hs_next;
                count_reg   <= count_next;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (go && s1_eob_reg)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_eob_reg)
        begin
            out_kind_reg    <= kind;
            out_buttons_reg <= buttons_next;
            out_lx_reg      <= lx_next;
            out_ly_reg      <= ly_next;
            out_rx_reg      <= rx_next;
            out_ry_reg      <= ry_next;
            out_side_reg    <= side_next;
            out_hs_reg      <= hs_next;
            out_baud_reg    <= (kind == KIND_BAUD);
            out_count_reg   <= count_next;
        end
    end

    assign out_ch.valid               = out_valid_reg;
    assign out_ch.packet_kind         = out_kind_reg;
    assign out_ch.merged_buttons      = out_buttons_reg;
    assign out_ch.left_stick_x        = out_lx_reg;
    assign out_ch.left_stick_y        = out_ly_reg;
    assign out_ch.right_stick_x       = out_rx_reg;
    assign out_ch.right_stick_y       = out_ry_reg;
    assign out_ch.side_select         = out_side_reg;
    assign out_ch.handshake_seen      = out_hs_reg;
    assign out_ch.baud_switch_request = out_baud_reg;
    assign out_ch.report_count        = out_count_reg;

`ifndef SYNTHESIS
    a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= CAP_POS_W'(CAPTURE_DEPTH))
        else $error("byte position past capture depth");

    a_side_code: assert property (@(posedge clk) disable iff (!rst_n)
        side_reg != 2'b11)
        else $error("side register holds an invalid code");

    a_pos_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (go && s1_eob_reg) |=> (pos_reg == '0))
        else $error("byte position not cleared after buffer end");

    a_baud_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_baud_reg == (out_kind_reg == KIND_BAUD)))
        else $error("baud request does not match packet kind");

    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (go && s1_eob_reg && (kind != KIND_INPUT)) |=> $stable(count_reg))
        else $error("report count changed without an input report");
`endif

endmodule

`default_nettype wire

// ===== tb/sv/gsrd_report_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsrd_report_checker
// Watches the byte and report channels of the gamepad serial report decoder.
// Keeps its own copy of the capture buffer, held pad state and register
// settings, works out the report due at each end-marked byte, and compares
// every report that leaves the block field by field against the oldest one
// still pending.
// ----------------------------------------------------------------------------

module gsrd_report_checker
    import gsrd_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    gsrd_in_if                         in_ch,
    gsrd_out_if                        out_ch,
    output int                         mismatch_count,
    output int                         reports_pending
);

    typedef struct packed {
        packet_kind_t        kind;
        logic [BUTTON_W-1:0] buttons;
        logic [7:0]          lx;
        logic [8:0]          ly;
        logic [7:0]          rx;
        logic [8:0]          ry;
        logic [1:0]          side;
        logic                handshake;
        logic                baud;
        logic [15:0]         count;
    } gamepad_report_t;

    logic [BUTTON_W-1:0] left_mask;
    logic [BUTTON_W-1:0] right_mask;
    logic [7:0]          right_mac;

    logic [7:0]          capture [CAPTURE_DEPTH];
    int                  fill_pos;
    logic [BUTTON_W-1:0] held_buttons;
    logic [7:0]          held_lx;
    logic [8:0]          held_ly;
    logic [7:0]          held_rx;
    logic [8:0]          held_ry;
    logic [1:0]          held_side;
    logic                handshake_flag;
    logic [15:0]         sample_count;

    gamepad_report_t     expected_reports [$];
    gamepad_report_t     want;

    function automatic int field_differs(string name, logic [23:0] exp_val,
                                         logic [23:0] act_val);
        if (act_val !== exp_val) begin
            $display("%0t: %s expected 0x%0h, actual 0x%0h", $time, name, exp_val, act_val);
            return 1;
        end
        return 0;
    endfunction

    task automatic absorb_byte(input logic [7:0] value, input logic last);
        logic [BUTTON_W-1:0] fresh;
        packet_kind_t        kind;
        if (fill_pos < CAPTURE_DEPTH) begin
            capture[fill_pos] = value;
            fill_pos++;
        end
        if (last) begin
            fresh = {capture[POS_BTN+2], capture[POS_BTN+1], capture[POS_BTN]};
            kind  = KIND_UNKNOWN;
            case (capture[POS_CMD])
                CMD_INPUT:
                begin
                    if (capture[POS_SUB] != SUB_INPUT_REPORT) begin
                        kind = KIND_UNKNOWN_SUB;
                    end else begin
                        if (held_side == SIDE_LEFT) begin
                            held_buttons = (held_buttons & ~left_mask) | (fresh & left_mask);
                            held_lx = {capture[POS_STICK+1][3:0], capture[POS_STICK][7:4]};
                            held_ly = STICK_Y_BASE - {1'b0, capture[POS_STICK+2]};
                        end
                        if (held_side == SIDE_RIGHT) begin
                            held_buttons = (held_buttons & ~right_mask) | (fresh & right_mask);
                            held_rx = {capture[POS_STICK+4][3:0], capture[POS_STICK+3][7:4]};
                            held_ry = STICK_Y_BASE - {1'b0, capture[POS_STICK+5]};
                        end
                        sample_count = sample_count + 16'd1;
                        kind = KIND_INPUT;
                    end
                end
                CMD_INIT:
                begin
                    case (capture[POS_INITSUB])
                        SUB_MAC:
                        begin
                            held_side = (capture[POS_MAC] != right_mac) ? SIDE_LEFT : SIDE_RIGHT;
                            kind = KIND_MAC;
                        end
                        SUB_BAUD:                         kind = KIND_BAUD;
                        SUB_INIT_A, SUB_INIT_B, SUB_INIT_C: kind = KIND_INIT_OTHER;
                        default:                          kind = KIND_UNKNOWN_SUB;
                    endcase
                end
                CMD_HANDSHAKE:
                begin
                    handshake_flag = 1'b1;
                    kind = KIND_HANDSHAKE;
                end
                default: kind = KIND_UNKNOWN;
            endcase
            expected_reports.push_back('{kind, held_buttons, held_lx, held_ly, held_rx,
                                         held_ry, held_side, handshake_flag,
                                         kind == KIND_BAUD, sample_count});
            foreach (capture[i]) capture[i] = 8'h00;
            fill_pos = 0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            left_mask      = LEFT_MASK_RESET;
            right_mask     = RIGHT_MASK_RESET;
            right_mac      = RIGHT_MAC_RESET;
            foreach (capture[i]) capture[i] = 8'h00;
            fill_pos       = 0;
            held_buttons   = '0;
            held_lx        = '0;
            held_ly        = '0;
            held_rx        = '0;
            held_ry        = '0;
            held_side      = SIDE_UNKNOWN;
            handshake_flag = 1'b0;
            sample_count   = '0;
            expected_reports.delete();
            mismatch_count  <= 0;
            reports_pending <= 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_LEFT_MASK:  left_mask  = cfg_data;
                    CFG_RIGHT_MASK: right_mask = cfg_data;
                    CFG_RIGHT_MAC:  right_mac  = cfg_data[7:0];
                    default:        ;
                endcase
            end
            if (out_ch.valid && out_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    $display("%0t: report expected none, actual kind %0d", $time,
                             out_ch.packet_kind);
                    mismatch_count <= mismatch_count + 1;
                end else begin
                    want = expected_reports.pop_front();
                    mismatch_count <= mismatch_count
                        + field_differs("packet_kind", want.kind, out_ch.packet_kind)
                        + field_differs("merged_buttons", want.buttons, out_ch.merged_buttons)
                        + field_differs("left_stick_x", want.lx, out_ch.left_stick_x)
                        + field_differs("left_stick_y", want.ly, out_ch.left_stick_y)
                        + field_differs("right_stick_x", want.rx, out_ch.right_stick_x)
                        + field_differs("right_stick_y", want.ry, out_ch.right_stick_y)
                        + field_differs("side_select", want.side, out_ch.side_select)
                        + field_differs("handshake_seen", want.handshake, out_ch.handshake_seen)
                        + field_differs("baud_switch_request", want.baud,
                                        out_ch.baud_switch_request)
                        + field_differs("report_count", want.count, out_ch.report_count);
                end
            end
            if (in_ch.valid && in_ch.ready) begin
                absorb_byte(in_ch.rx_byte, in_ch.end_of_buffer);
            end
            reports_pending <= expected_reports.size();
        end
    end

endmodule

// ===== tb/sv/gamepad_serial_report_decoder_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_serial_report_decoder_unit_tb
// Drives serial buffers into the report decoder: a directed set of packets
// for every command, subcommand, buffer length corner and side, then random
// packet streams under several register settings, with random gaps and
// stalls, a long result hold-off and full drains. The checker beside the
// block predicts and compares every report.
// ----------------------------------------------------------------------------

module gamepad_serial_report_decoder_unit_tb;
    import gsrd_pkg::*;

    localparam int RESET_CYCLES  = 5;
    localparam int BYTE_TARGET   = 1850;
    localparam int PHASES        = 5;
    localparam int PKT_MAX       = 32;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 400;
    localparam int CYCLE_LIMIT   = 400000;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED   = 2'd3;
    localparam logic [7:0]           SUB_UNLISTED = 8'h02;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    int                    mismatch_count;
    int                    reports_pending;
    int                    cycle_count = 0;
    int                    bytes_sent = 0;
    int                    sink_stall;

    logic [7:0]            pkt [PKT_MAX];
    int                    pkt_len;
    logic [7:0]            mac_now = RIGHT_MAC_RESET;
    bit                    sender_steady = 1'b0;
    bit                    sink_steady = 1'b0;
    bit                    hold_request = 1'b0;

    gsrd_in_if  in_ch ();
    gsrd_out_if out_ch ();

    gamepad_serial_report_decoder_unit u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    gsrd_report_checker u_report_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_ch           (in_ch),
        .out_ch          (out_ch),
        .mismatch_count  (mismatch_count),
        .reports_pending (reports_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_byte(input logic [7:0] value, input logic last);
        int gap;
        gap = sender_steady ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid         <= 1'b1;
        in_ch.rx_byte       <= value;
        in_ch.end_of_buffer <= last;
        @(posedge clk);
        while (!in_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_packet();
        for (int i = 0; i < pkt_len; i++) begin
            send_byte(pkt[i], i == pkt_len - 1);
        end
    endtask

    task automatic shape_packet(input int len, input logic [7:0] cmd, input logic [7:0] sub,
                                input bit random_body, input logic [7:0] fill);
        pkt_len = len;
        foreach (pkt[i]) pkt[i] = random_body ? 8'($urandom) : fill;
        pkt[POS_CMD] = cmd;
        if (cmd == CMD_INPUT) begin
            pkt[POS_SUB] = sub;
        end else begin
            pkt[POS_INITSUB] = sub;
        end
    endtask

    // block may still be absorbing bytes of a buffer with no end mark
    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (reports_pending != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_config(input logic [BUTTON_W-1:0] lmask,
                                input logic [BUTTON_W-1:0] rmask, input logic [7:0] mac);
        wait_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_LEFT_MASK;
        cfg_data  <= lmask;
        @(posedge clk);
        cfg_index <= CFG_RIGHT_MASK;
        cfg_data  <= rmask;
        @(posedge clk);
        cfg_index <= CFG_RIGHT_MAC;
        cfg_data  <= {16'($urandom), mac};
        @(posedge clk);
        cfg_index <= CFG_UNUSED;
        cfg_data  <= 24'($urandom);
        @(posedge clk);
        cfg_we    <= 1'b0;
        mac_now = mac;
    endtask

    task automatic random_packet();
        int         sel;
        int         len;
        logic [7:0] sub;
        sel = $urandom_range(0, 99);
        if (sel < 45) begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 23) : $urandom_range(24, 30);
            shape_packet(len, CMD_INPUT, SUB_INPUT_REPORT, 1'b1, 8'h00);
        end else if (sel < 60) begin
            shape_packet($urandom_range(19, 26), CMD_INIT, SUB_MAC, 1'b1, 8'h00);
            pkt[POS_MAC] = $urandom_range(0, 1) ? mac_now : 8'($urandom);
        end else if (sel < 65) begin
            shape_packet($urandom_range(7, 24), CMD_INIT, SUB_BAUD, 1'b1, 8'h00);
        end else if (sel < 70) begin
            case ($urandom_range(0, 2))
                0:       sub = SUB_INIT_A;
                1:       sub = SUB_INIT_B;
                default: sub = SUB_INIT_C;
            endcase
            shape_packet($urandom_range(7, 24), CMD_INIT, sub, 1'b1, 8'h00);
        end else if (sel < 74) begin
            shape_packet($urandom_range(6, 24), CMD_HANDSHAKE, 8'($urandom), 1'b1, 8'h00);
        end else if (sel < 80) begin
            shape_packet($urandom_range(13, 28), $urandom_range(0, 1) ? CMD_INPUT : CMD_INIT,
                         8'($urandom), 1'b1, 8'h00);
        end else if (sel < 92) begin
            shape_packet($urandom_range(1, PKT_MAX), 8'($urandom), 8'($urandom), 1'b1, 8'h00);
        end else begin
            shape_packet($urandom_range(1, 6), 8'($urandom), 8'($urandom), 1'b1, 8'h00);
        end
        send_packet();
    endtask

    // result side: random stalls, steady stretches, one long hold-off on request
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                out_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
            sink_stall = sink_steady ? 0 : $urandom_range(0, 19);
            if (sink_stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (sink_stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
            while (!out_ch.valid) @(posedge clk);
        end
    end

    initial
    begin : stimulus
        int phase;
        int phase_end;
        rst_n               <= 1'b0;
        cfg_we              <= 1'b0;
        cfg_index           <= CFG_LEFT_MASK;
        cfg_data            <= '0;
        in_ch.valid         <= 1'b0;
        in_ch.rx_byte       <= 8'h00;
        in_ch.end_of_buffer <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // lone byte, report before any side is known, right and left sides
        shape_packet(1, 8'h00, 8'h00, 1'b0, 8'hFF);
        send_packet();
        shape_packet(CAPTURE_DEPTH, CMD_INPUT, SUB_INPUT_REPORT, 1'b0, 8'hFF);
        send_packet();
        shape_packet(POS_MAC + 1, CMD_INIT, SUB_MAC, 1'b0, 8'h00);
        pkt[POS_MAC] = mac_now;
        send_packet();
        shape_packet(CAPTURE_DEPTH, CMD_INPUT, SUB_INPUT_REPORT, 1'b0, 8'hFF);
        send_packet();
        shape_packet(POS_MAC + 1, CMD_INIT, SUB_MAC, 1'b0, 8'hFF);
        send_packet();
        // over-long buffer, tail bytes must be dropped
        shape_packet(30, CMD_INPUT, SUB_INPUT_REPORT, 1'b0, 8'h00);
        for (int i = CAPTURE_DEPTH; i < pkt_len; i++) pkt[i] = 8'hFF;
        send_packet();
        shape_packet(POS_INITSUB + 1, CMD_INIT, SUB_BAUD, 1'b0, 8'h00);
        send_packet();
        shape_packet(POS_INITSUB + 1, CMD_INIT, SUB_INIT_A, 1'b1, 8'h00);
        send_packet();
        shape_packet(POS_INITSUB + 1, CMD_INIT, SUB_INIT_B, 1'b1, 8'h00);
        send_packet();
        shape_packet(POS_INITSUB + 1, CMD_INIT, SUB_INIT_C, 1'b1, 8'h00);
        send_packet();
        shape_packet(POS_INITSUB + 1, CMD_INIT, SUB_UNLISTED, 1'b1, 8'h00);
        send_packet();
        shape_packet(CAPTURE_DEPTH, CMD_INPUT, SUB_MAC, 1'b1, 8'h00);
        send_packet();
        shape_packet(POS_CMD + 1, CMD_HANDSHAKE, 8'h00, 1'b1, 8'h00);
        send_packet();
        shape_packet(3, 8'($urandom), 8'h00, 1'b1, 8'h00);
        send_packet();

        for (phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0:       write_config('1, '1, 8'hFF);
                1:       write_config('0, '0, 8'h00);
                default: write_config(24'($urandom), 24'($urandom), 8'($urandom));
            endcase
            if (phase == 2) begin
                // results held back while requests keep coming
                hold_request  = 1'b1;
                sender_steady = 1'b1;
                repeat (12) begin
                    shape_packet($urandom_range(1, 8), 8'($urandom), 8'($urandom), 1'b1, 8'h00);
                    send_packet();
                end
            end
            phase_end = bytes_sent + BYTE_TARGET / PHASES;
            while (bytes_sent < phase_end) begin
                sender_steady = ($urandom_range(0, 3) == 0);
                if ($urandom_range(0, 39) == 0) wait_drained();
                random_packet();
            end
        end

        wait_drained();
        if (mismatch_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== gamepad_serial_report_decoder_unit.f =====
rtl/gsrd_pkg.sv
rtl/gsrd_in_if.sv
rtl/gsrd_out_if.sv
rtl/gamepad_serial_report_decoder_unit.sv
tb/sv/gsrd_report_checker.sv
tb/sv/gamepad_serial_report_decoder_unit_tb.sv
